// ===== rtl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// quaternion parts: signed Q2.14
	localparam int Q_BITS = 16;
	localparam int Q_FRAC = 14;
	// round half up before dropping Q_FRAC bits
	localparam int Q_HALF = 1 << (Q_FRAC - 1);

	// 1.0 in Q2.14
	localparam logic signed [Q_BITS-1:0] SCALAR_RESET = 16'sd16384;

	// APB side
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_SCALAR,
		REG_X,
		REG_Y,
		REG_Z
	} reg_idx_t;

endpackage

// ===== rtl/quaternion_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a stream of 3-D fixed-point vectors by a quaternion held in
// APB registers: t = u x V, R = V + 2w*t + 2*(u x t), rounded and saturated.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one word per cycle while in_ready is high: in_x/y/z,
//    signed, 12 fraction bits, VEC_BITS wide.
//  - Output channel (out_valid/out_ready) gives one word per input word:
//    out_x/y/z in the same format, saturated, and clipped when any
//    component hit the range limit.
//  - Throughput is one word per cycle while out_ready stays high.
//  - Five pipeline stages: s1 u*V products, s2 t = u x V rounded,
//    s3 w*t and u*t products, s4 three-term sum rounded, s5 saturation.
//    Each stage has its own valid bit and moves when it is empty or the
//    stage after it moves, so bubbles close up under a stall.
//  - When out_ready is low the last stage holds its word; earlier stages
//    keep filling until all five are full, then in_ready drops.
//  - Quaternion registers (rot_scalar, rot_x, rot_y, rot_z; Q2.14) sit at
//    byte addresses 0, 4, 8, 12. Write them only while the pipeline is empty.
//  - Reset empties the pipeline and loads the identity quaternion (1, 0).
// ----------------------------------------------------------------------------
module quaternion_vector_rotate
	import qvr_pkg::*;
#(
	parameter int VEC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB config
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_AW-1:0]          paddr,
	input  logic [APB_DW-1:0]          pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready,
	// input words
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [VEC_BITS-1:0] in_x,
	input  logic signed [VEC_BITS-1:0] in_y,
	input  logic signed [VEC_BITS-1:0] in_z,
	// output words
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VEC_BITS-1:0] out_x,
	output logic signed [VEC_BITS-1:0] out_y,
	output logic signed [VEC_BITS-1:0] out_z,
	output logic                       clipped
);

	// widths through the datapath
	localparam int PW  = VEC_BITS + Q_BITS;   // u*V product
	localparam int DW  = PW + 1;              // difference of products
	localparam int TW  = DW - Q_FRAC;         // t after rounding
	localparam int P2W = TW + Q_BITS;         // u*t, w*t products
	localparam int SW  = P2W + 4;             // full-precision sum
	localparam int RW  = SW - Q_FRAC;         // sum after rounding
	localparam int NS  = 5;                   // pipeline stages

	localparam logic [VEC_BITS-1:0] VMAX = {1'b0, {(VEC_BITS-1){1'b1}}};
	localparam logic [VEC_BITS-1:0] VMIN = {1'b1, {(VEC_BITS-1){1'b0}}};

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic signed [Q_BITS-1:0] rot_scalar_q, rot_x_q, rot_y_q, rot_z_q;
	reg_idx_t                 reg_idx;
	logic                     cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_scalar_q <= SCALAR_RESET;
			rot_x_q      <= '0;
			rot_y_q      <= '0;
			rot_z_q      <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SCALAR: rot_scalar_q <= pwdata[Q_BITS-1:0];
				REG_X:      rot_x_q      <= pwdata[Q_BITS-1:0];
				REG_Y:      rot_y_q      <= pwdata[Q_BITS-1:0];
				REG_Z:      rot_z_q      <= pwdata[Q_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCALAR: prdata = {{(APB_DW-Q_BITS){1'b0}}, rot_scalar_q};
			REG_X:      prdata = {{(APB_DW-Q_BITS){1'b0}}, rot_x_q};
			REG_Y:      prdata = {{(APB_DW-Q_BITS){1'b0}}, rot_y_q};
			REG_Z:      prdata = {{(APB_DW-Q_BITS){1'b0}}, rot_z_q};
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: stage k moves when empty or when k+1 moves
	// ------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS:0]   go;

	always_comb begin
		go[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			go[k] = !vld_q[k] || go[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (go[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (go[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_ready  = go[0];
	assign out_valid = vld_q[NS-1];

	// ------------------------------------------------------------------
	// s1: products u*V
	// ------------------------------------------------------------------
	logic signed [PW-1:0]       a_yz_s1, a_zy_s1, a_zx_s1, a_xz_s1, a_xy_s1, a_yx_s1;
	logic signed [VEC_BITS-1:0] vx_s1, vy_s1, vz_s1;

	qvr_cross_mul #(.BW(VEC_BITS)) u_mul_uv (
		.clk  (clk),
		.en   (go[0]),
		.a_x  (rot_x_q),
		.a_y  (rot_y_q),
		.a_z  (rot_z_q),
		.b_x  (in_x),
		.b_y  (in_y),
		.b_z  (in_z),
		.p_yz (a_yz_s1),
		.p_zy (a_zy_s1),
		.p_zx (a_zx_s1),
		.p_xz (a_xz_s1),
		.p_xy (a_xy_s1),
		.p_yx (a_yx_s1)
	);

	always_ff @(posedge clk) begin
		if (go[0]) begin
			vx_s1 <= in_x;
			vy_s1 <= in_y;
			vz_s1 <= in_z;
		end
	end

	// ------------------------------------------------------------------
	// s2: t = round(u x V), kept at full width
	// ------------------------------------------------------------------
	logic signed [DW-1:0]       dx, dy, dz;
	logic signed [TW-1:0]       tx_s2, ty_s2, tz_s2;
	logic signed [VEC_BITS-1:0] vx_s2, vy_s2, vz_s2;

	assign dx = DW'(a_yz_s1) - DW'(a_zy_s1) + DW'(Q_HALF);
	assign dy = DW'(a_zx_s1) - DW'(a_xz_s1) + DW'(Q_HALF);
	assign dz = DW'(a_xy_s1) - DW'(a_yx_s1) + DW'(Q_HALF);

	always_ff @(posedge clk) begin
		if (go[1]) begin
			tx_s2 <= dx[DW-1:Q_FRAC];
			ty_s2 <= dy[DW-1:Q_FRAC];
			tz_s2 <= dz[DW-1:Q_FRAC];
			vx_s2 <= vx_s1;
			vy_s2 <= vy_s1;
			vz_s2 <= vz_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3: products w*t and u*t
	// ------------------------------------------------------------------
	logic signed [P2W-1:0]      b_yz_s3, b_zy_s3, b_zx_s3, b_xz_s3, b_xy_s3, b_yx_s3;
	logic signed [P2W-1:0]      wtx_s3, wty_s3, wtz_s3;
	logic signed [VEC_BITS-1:0] vx_s3, vy_s3, vz_s3;

	qvr_cross_mul #(.BW(TW)) u_mul_ut (
		.clk  (clk),
		.en   (go[2]),
		.a_x  (rot_x_q),
		.a_y  (rot_y_q),
		.a_z  (rot_z_q),
		.b_x  (tx_s2),
		.b_y  (ty_s2),
		.b_z  (tz_s2),
		.p_yz (b_yz_s3),
		.p_zy (b_zy_s3),
		.p_zx (b_zx_s3),
		.p_xz (b_xz_s3),
		.p_xy (b_xy_s3),
		.p_yx (b_yx_s3)
	);

	always_ff @(posedge clk) begin
		if (go[2]) begin
			wtx_s3 <= P2W'(rot_scalar_q) * P2W'(tx_s2);
			wty_s3 <= P2W'(rot_scalar_q) * P2W'(ty_s2);
			wtz_s3 <= P2W'(rot_scalar_q) * P2W'(tz_s2);
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			vz_s3  <= vz_s2;
		end
	end

	// ------------------------------------------------------------------
	// s4: R = V<<14 + 2wt + 2(u x t), rounded to 12 fraction bits
	// ------------------------------------------------------------------
	logic signed [SW-1:0] sx, sy, sz;
	logic signed [RW-1:0] rx_s4, ry_s4, rz_s4;

	assign sx = (SW'(vx_s3) <<< Q_FRAC) + (SW'(wtx_s3) <<< 1)
	          + ((SW'(b_yz_s3) - SW'(b_zy_s3)) <<< 1) + SW'(Q_HALF);
	assign sy = (SW'(vy_s3) <<< Q_FRAC) + (SW'(wty_s3) <<< 1)
	          + ((SW'(b_zx_s3) - SW'(b_xz_s3)) <<< 1) + SW'(Q_HALF);
	assign sz = (SW'(vz_s3) <<< Q_FRAC) + (SW'(wtz_s3) <<< 1)
	          + ((SW'(b_xy_s3) - SW'(b_yx_s3)) <<< 1) + SW'(Q_HALF);

	always_ff @(posedge clk) begin
		if (go[3]) begin
			rx_s4 <= sx[SW-1:Q_FRAC];
			ry_s4 <= sy[SW-1:Q_FRAC];
			rz_s4 <= sz[SW-1:Q_FRAC];
		end
	end

	// ------------------------------------------------------------------
	// s5: saturate to VEC_BITS; MSB of the result is the clip flag
	// ------------------------------------------------------------------
	function automatic logic [VEC_BITS:0] sat_f(input logic signed [RW-1:0] r);
		logic [RW-VEC_BITS:0] hi;
		hi = r[RW-1:VEC_BITS-1];
		if (hi == '0 || hi == '1) return {1'b0, r[VEC_BITS-1:0]};
		else if (r[RW-1])         return {1'b1, VMIN};
		else                      return {1'b1, VMAX};
	endfunction

	logic [VEC_BITS:0]          sat_x, sat_y, sat_z;
	logic signed [VEC_BITS-1:0] ox_s5, oy_s5, oz_s5;
	logic                       clip_s5;

	always_comb begin
		sat_x = sat_f(rx_s4);
		sat_y = sat_f(ry_s4);
		sat_z = sat_f(rz_s4);
	end

	always_ff @(posedge clk) begin
		if (go[4]) begin
			ox_s5   <= sat_x[VEC_BITS-1:0];
			oy_s5   <= sat_y[VEC_BITS-1:0];
			oz_s5   <= sat_z[VEC_BITS-1:0];
			clip_s5 <= sat_x[VEC_BITS] | sat_y[VEC_BITS] | sat_z[VEC_BITS];
		end
	end

	assign out_x   = ox_s5;
	assign out_y   = oy_s5;
	assign out_z   = oz_s5;
	assign clipped = clip_s5;

`ifndef NO_ASSERTIONS
	// accepted word lands in s1
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted word did not enter s1");

	// backpressure only when every stage holds a word
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_q == {NS{1'b1}}))
		else $error("in_ready low with a bubble in the pipeline");

	// a blocked middle stage keeps its word
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[2] && !go[3] |=> vld_q[2] && $stable(wtx_s3) && $stable(wtz_s3))
		else $error("s3 word lost under stall");

	// a clipped word has a component at a range limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (out_x == VMAX || out_x == VMIN ||
		                          out_y == VMAX || out_y == VMIN ||
		                          out_z == VMAX || out_z == VMIN))
		else $error("clip flag set without a saturated component");
`endif

endmodule

// ===== rtl/qvr_cross_mul.sv =====
// ----------------------------------------------------------------------------
// qvr_cross_mul
// Registered partial products of a cross product a x b (six multipliers).
// ----------------------------------------------------------------------------
module qvr_cross_mul
	import qvr_pkg::*;
#(
	parameter int BW = 24
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [Q_BITS-1:0]     a_x,
	input  logic signed [Q_BITS-1:0]     a_y,
	input  logic signed [Q_BITS-1:0]     a_z,
	input  logic signed [BW-1:0]         b_x,
	input  logic signed [BW-1:0]         b_y,
	input  logic signed [BW-1:0]         b_z,
	output logic signed [BW+Q_BITS-1:0]  p_yz,
	output logic signed [BW+Q_BITS-1:0]  p_zy,
	output logic signed [BW+Q_BITS-1:0]  p_zx,
	output logic signed [BW+Q_BITS-1:0]  p_xz,
	output logic signed [BW+Q_BITS-1:0]  p_xy,
	output logic signed [BW+Q_BITS-1:0]  p_yx
);

	localparam int PW = BW + Q_BITS;

	logic signed [PW-1:0] p_yz_q, p_zy_q, p_zx_q, p_xz_q, p_xy_q, p_yx_q;

	// x: a_y*b_z - a_z*b_y, y: a_z*b_x - a_x*b_z, z: a_x*b_y - a_y*b_x
	always_ff @(posedge clk) begin
		if (en) begin
			p_yz_q <= PW'(a_y) * PW'(b_z);
			p_zy_q <= PW'(a_z) * PW'(b_y);
			p_zx_q <= PW'(a_z) * PW'(b_x);
			p_xz_q <= PW'(a_x) * PW'(b_z);
			p_xy_q <= PW'(a_x) * PW'(b_y);
			p_yx_q <= PW'(a_y) * PW'(b_x);
		end
	end

	assign p_yz = p_yz_q;
	assign p_zy = p_zy_q;
	assign p_zx = p_zx_q;
	assign p_xz = p_xz_q;
	assign p_xy = p_xy_q;
	assign p_yx = p_yx_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_vector_rotate. Sends vectors through
// the input channel, predicts each rotated word from a local copy of the
// quaternion registers, and compares the words at the output in order.
// The quaternion is reloaded over APB between phases, always with the
// pipeline drained. Each register is read back after it is written.
// ----------------------------------------------------------------------------
module tb_top;
	import qvr_pkg::*;

	localparam int VB        = 24;
	localparam int LATENCY   = 5;
	localparam int CYCLE_CAP = 200000;
	localparam int ROT_COUNT = 5;    // quaternions per idle phase
	localparam int WORDS_PER = 100;  // words per quaternion in the random part

	localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 1;
	localparam longint VMIN = -(64'sd1 <<< (VB - 1));

	typedef struct packed {
		logic [VB-1:0] x;
		logic [VB-1:0] y;
		logic [VB-1:0] z;
	} vec_t;

	typedef struct packed {
		logic [VB-1:0] x;
		logic [VB-1:0] y;
		logic [VB-1:0] z;
		logic          clip;
	} rotated_t;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [VB-1:0] in_x;
	logic signed [VB-1:0] in_y;
	logic signed [VB-1:0] in_z;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [VB-1:0] out_x;
	logic signed [VB-1:0] out_y;
	logic signed [VB-1:0] out_z;
	logic                 clipped;

	// local copy of the quaternion registers, Q2.14
	logic signed [Q_BITS-1:0] quat_w;
	logic signed [Q_BITS-1:0] quat_x;
	logic signed [Q_BITS-1:0] quat_y;
	logic signed [Q_BITS-1:0] quat_z;

	rotated_t rotated_q[$];   // rotated words still owed by the block

	int errors = 0;
	int cycles = 0;
	int src_idle_pct;         // chance per cycle that the sender holds off
	int snk_stall_pct;        // chance per cycle that the receiver stalls

	quaternion_vector_rotate #(
		.VEC_BITS(VB)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.clipped   (clipped)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Rotation predictor
	// ------------------------------------------------------------------

	// round half up from 26 to 12 fraction bits; >>> on a signed value
	// floors, which is what the datapath does
	function automatic longint round_q14(longint a);
		return (a + Q_HALF) >>> Q_FRAC;
	endfunction

	function automatic rotated_t rotate_vector(vec_t v);
		longint w, ux, uy, uz;
		longint vx, vy, vz;
		longint tx, ty, tz;
		longint r[3];
		rotated_t res;
		w  = longint'(quat_w);
		ux = longint'(quat_x);
		uy = longint'(quat_y);
		uz = longint'(quat_z);
		vx = longint'($signed(v.x));
		vy = longint'($signed(v.y));
		vz = longint'($signed(v.z));
		// t = u x V, rounded but kept at full width
		tx = round_q14(uy * vz - uz * vy);
		ty = round_q14(uz * vx - ux * vz);
		tz = round_q14(ux * vy - uy * vx);
		// R = V + 2w*t + 2*(u x t), all at 26 fraction bits
		r[0] = (vx <<< Q_FRAC) + 2 * w * tx + 2 * (uy * tz - uz * ty);
		r[1] = (vy <<< Q_FRAC) + 2 * w * ty + 2 * (uz * tx - ux * tz);
		r[2] = (vz <<< Q_FRAC) + 2 * w * tz + 2 * (ux * ty - uy * tx);
		res.clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			r[i] = round_q14(r[i]);
			if (r[i] > VMAX) begin
				r[i] = VMAX;
				res.clip = 1'b1;
			end else if (r[i] < VMIN) begin
				r[i] = VMIN;
				res.clip = 1'b1;
			end
		end
		res.x = r[0][VB-1:0];
		res.y = r[1][VB-1:0];
		res.z = r[2][VB-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// one vector word; valid stays up after acceptance until the next call
	// or drop_input lowers it at a later falling edge
	task automatic send_vector(vec_t v);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_x     <= v.x;
		in_y     <= v.y;
		in_z     <= v.z;
		do @(posedge clk); while (!in_ready);
		rotated_q.push_back(rotate_vector(v));
	endtask

	task automatic drop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// every owed word out, then a few spare cycles to catch strays
	task automatic drain();
		while (rotated_q.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// APB side
	// ------------------------------------------------------------------

	// upper pwdata bits are junk on purpose; the block keeps the low 16
	task automatic write_reg(reg_idx_t idx, logic [Q_BITS-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_SCALAR: quat_w = val;
			REG_X:      quat_x = val;
			REG_Y:      quat_y = val;
			REG_Z:      quat_z = val;
			default:    ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_reg(reg_idx_t idx);
		logic [Q_BITS-1:0] want;
		case (idx)
			REG_SCALAR: want = quat_w;
			REG_X:      want = quat_x;
			REG_Y:      want = quat_y;
			default:    want = quat_z;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[Q_BITS-1:0] !== want) begin
			errors++;
			$display("%0t: reg %s read expected %h actual %h",
				$realtime, idx.name(), want, prdata[Q_BITS-1:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// only touched with the pipeline empty
	task automatic set_rotation(logic [15:0] w, logic [15:0] x,
		logic [15:0] y, logic [15:0] z);
		drop_input();
		drain();
		write_reg(REG_SCALAR, w);
		write_reg(REG_X, x);
		write_reg(REG_Y, y);
		write_reg(REG_Z, z);
		read_reg(REG_SCALAR);
		read_reg(REG_X);
		read_reg(REG_Y);
		read_reg(REG_Z);
	endtask

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin : check_out
		rotated_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rotated_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word expected none actual %h %h %h %b",
					$realtime, out_x, out_y, out_z, clipped);
			end else begin
				want = rotated_q.pop_front();
				if (out_x !== want.x || out_y !== want.y ||
					out_z !== want.z || clipped !== want.clip) begin
					errors++;
					$display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b",
						$realtime, want.x, want.y, want.z, want.clip,
						out_x, out_y, out_z, clipped);
				end
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic vec_t mk_vec(longint x, longint y, longint z);
		vec_t v;
		v.x = x[VB-1:0];
		v.y = y[VB-1:0];
		v.z = z[VB-1:0];
		return v;
	endfunction

	// half full-range, half shrunk toward zero so not everything clips
	function automatic logic [VB-1:0] rand_comp();
		logic signed [VB-1:0] r;
		r = VB'($urandom);
		if ($urandom_range(1))
			r = r >>> $urandom_range(VB - 1, 0);
		return r;
	endfunction

	function automatic logic [15:0] rand_quat_part(int kind);
		logic [15:0] pick[4];
		pick = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000};
		case (kind)
			0:       return 16'($urandom);
			1:       return 16'($signed($urandom_range(23170)) - 11585);
			default: return pick[$urandom_range(3)];
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset quaternion is identity: words pass through untouched
	task automatic test_identity();
		read_reg(REG_SCALAR);
		read_reg(REG_X);
		read_reg(REG_Y);
		read_reg(REG_Z);
		send_vector(mk_vec(0, 0, 0));
		send_vector(mk_vec(VMAX, VMAX, VMAX));
		send_vector(mk_vec(VMIN, VMIN, VMIN));
		send_vector(mk_vec(VMAX, VMIN, 1));
		send_vector(mk_vec(-1, 1, 4095));
		send_vector(mk_vec(24'haaaaaa, 24'h555555, 24'haaaaaa));
	endtask

	// oversized quaternions, to push full-range vectors into the rails
	task automatic test_saturation();
		set_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_vector(mk_vec(VMAX, VMAX, VMAX));
		send_vector(mk_vec(VMIN, VMIN, VMIN));
		send_vector(mk_vec(VMAX, VMIN, 0));
		send_vector(mk_vec(1, -1, 1));
		set_rotation(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_vector(mk_vec(VMAX, VMIN, VMAX));
		send_vector(mk_vec(VMIN, VMAX, VMIN));
		send_vector(mk_vec(4096, 0, 0));
	endtask

	// quarter turn about z, the zero quaternion, and exact halves at
	// the rounding of t
	task automatic test_rotation_rounding();
		set_rotation(16'd11585, 16'd0, 16'd0, 16'd11585);
		send_vector(mk_vec(4096, 0, 0));
		send_vector(mk_vec(0, 4096, 0));
		send_vector(mk_vec(VMAX, 0, 0));
		set_rotation(16'd0, 16'd0, 16'd0, 16'd0);
		send_vector(mk_vec(VMAX, VMIN, 0));
		// u.x of one lsb: t.z lands on +0.5 and -0.5
		set_rotation(16'd16384, 16'd1, 16'd0, 16'd0);
		send_vector(mk_vec(0, 8192, 0));
		send_vector(mk_vec(0, -8192, 0));
	endtask

	// random streams under each idling mix, fresh quaternion every block
	task automatic test_random_stream();
		int src_mix[4];
		int snk_mix[4];
		int kind;
		vec_t v;
		src_mix = '{0, 47, 0, 6};
		snk_mix = '{0, 0, 47, 6};
		for (int ph = 0; ph < 4; ph++) begin
			for (int q = 0; q < ROT_COUNT; q++) begin
				kind = $urandom_range(2);
				set_rotation(rand_quat_part(kind), rand_quat_part(kind),
					rand_quat_part(kind), rand_quat_part(kind));
				// idle mix changes only with the pipe drained
				src_idle_pct  = src_mix[ph];
				snk_stall_pct = snk_mix[ph];
				for (int n = 0; n < WORDS_PER; n++) begin
					v.x = rand_comp();
					v.y = rand_comp();
					v.z = rand_comp();
					send_vector(v);
				end
			end
		end
		src_idle_pct  = 0;
		snk_stall_pct = 0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		in_x          = '0;
		in_y          = '0;
		in_z          = '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		quat_w        = SCALAR_RESET;
		quat_x        = '0;
		quat_y        = '0;
		quat_z        = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_identity();
		test_saturation();
		test_rotation_rounding();
		test_random_stream();

		drop_input();
		drain();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
